### rtl/core/tlet_pkg.sv
// Shared types and constants of the training load EWMA tracker.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tlet_pkg;

   // Defaults for the top level parameters.
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int LOAD_BITS_DEF     = 20;

   // Field widths.
   localparam int DECAY_W  = 16;
   localparam int WIN_W    = 6;
   localparam int DAYS_W   = 6;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Day counter saturates here.
   localparam logic [DAYS_W-1:0] DAYS_MAX = 6'd63;

   // Register reset values.
   localparam logic [DECAY_W-1:0] LONG_DECAY_RST  = 16'd63994;   // 42 days
   localparam logic [DECAY_W-1:0] SHORT_DECAY_RST = 16'd56812;   // 7 days
   localparam logic [WIN_W-1:0]   WINDOW_DAYS_RST = 6'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_DECAY    = 2'd0,
      CSR_SHORT_DECAY   = 2'd1,
      CSR_WINDOW_DAYS   = 2'd2,
      CSR_BALANCE_TODAY = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

### rtl/core/tlet_if.sv
// Valid/ready channel interfaces of the training load EWMA tracker.
// Depends on tlet_pkg for the default load width.
`timescale 1ns / 1ps
`default_nettype none

interface tlet_req_if
   import tlet_pkg::*;
#(
   parameter int LOAD_BITS = LOAD_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic                 first_day;
   logic [LOAD_BITS-1:0] day_stress;
   logic                 seeded;
   logic [LOAD_BITS-1:0] seed_load;

   modport source (output valid, first_day, day_stress, seeded, seed_load, input ready);
   modport sink   (input valid, first_day, day_stress, seeded, seed_load, output ready);
endinterface

interface tlet_rsp_if
   import tlet_pkg::*;
#(
   parameter int LOAD_BITS = LOAD_BITS_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic [LOAD_BITS-1:0]        long_load;
   logic [LOAD_BITS-1:0]        short_load;
   logic signed [LOAD_BITS:0]   balance;
   logic signed [LOAD_BITS:0]   ramp;

   modport source (output valid, long_load, short_load, balance, ramp, input ready);
   modport sink   (input valid, long_load, short_load, balance, ramp, output ready);
endinterface

`default_nettype wire

### rtl/core/tlet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the long load history of the tracker.
`timescale 1ns / 1ps
`default_nettype none

module tlet_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/training_load_ewma_tracker.sv
// Training load tracker: long/short EWMA loads, stress balance and ramp rate.
// Path: an accepted req transaction passes the stage 1 and output registers to rsp.
// Throughput: one transaction per cycle unless rsp stalls; the loads recur through a
//   single multiply-add per average, the history RAM is read once per day.
// Reset (synchronous, active high) restores register defaults and clears loads and day
//   count; the history RAM is not cleared and only days already written are used.
// Depends on tlet_pkg, tlet_if (tlet_req_if, tlet_rsp_if) and tlet_ram.
`timescale 1ns / 1ps
`default_nettype none

module training_load_ewma_tracker
   import tlet_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int LOAD_BITS     = LOAD_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tlet_req_if.sink                  req,
   tlet_rsp_if.source                rsp,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // Pointer and window arithmetic: CNT_W holds HISTORY_DEPTH and the window.
   localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
   localparam int GAIN_W = DECAY_W + 2;               // signed, 1..2^16
   localparam int PROD_W = LOAD_BITS + 1 + GAIN_W;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] WIN_CAP  = CNT_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(HISTORY_DEPTH);
   localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

   // One EWMA update: last + floor((stress - last) * (1 - decay)), clamped.
   // The arithmetic right shift of the product gives the floor.
   function automatic logic [LOAD_BITS-1:0] ewma_step(
      input logic [LOAD_BITS-1:0] last,
      input logic [LOAD_BITS-1:0] stress,
      input logic [DECAY_W-1:0]   decay
   );
      logic signed [LOAD_BITS:0]   diff;
      logic signed [GAIN_W-1:0]    gain;
      logic signed [PROD_W-1:0]    prod;
      logic signed [LOAD_BITS+1:0] delta;
      logic signed [LOAD_BITS+1:0] sum;
      diff  = $signed({1'b0, stress}) - $signed({1'b0, last});
      gain  = $signed({2'b01, {DECAY_W{1'b0}}}) - $signed({2'b00, decay});
      prod  = PROD_W'(diff) * PROD_W'(gain);
      delta = $signed(prod[DECAY_W+LOAD_BITS+1:DECAY_W]);
      sum   = $signed({2'b00, last}) + delta;
      if (sum[LOAD_BITS+1]) begin
         ewma_step = '0;
      end else if (sum[LOAD_BITS]) begin
         ewma_step = LOAD_MAX;
      end else begin
         ewma_step = sum[LOAD_BITS-1:0];
      end
   endfunction

   // Difference of two loads always fits the signed field; no clamp needed.
   function automatic logic signed [LOAD_BITS:0] load_diff(
      input logic [LOAD_BITS-1:0] a,
      input logic [LOAD_BITS-1:0] b
   );
      load_diff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DECAY_W-1:0] long_decay_ff;
   logic [DECAY_W-1:0] short_decay_ff;
   logic [WIN_W-1:0]   window_days_ff;
   logic               balance_today_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_decay_ff    <= LONG_DECAY_RST;
         short_decay_ff   <= SHORT_DECAY_RST;
         window_days_ff   <= WINDOW_DAYS_RST;
         balance_today_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LONG_DECAY:    long_decay_ff    <= csr_wdata[DECAY_W-1:0];
            CSR_SHORT_DECAY:   short_decay_ff   <= csr_wdata[DECAY_W-1:0];
            CSR_WINDOW_DAYS:   window_days_ff   <= csr_wdata[WIN_W-1:0];
            CSR_BALANCE_TODAY: balance_today_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: stage 1 (loads, history read) and output register.
   // Each stage moves on when the one after it is empty or moving.
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic out_valid_ff;
   logic out_adv;
   logic s1_adv;
   logic accept;

   assign out_adv   = !out_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && out_adv;
   assign req.ready = !s1_valid_ff || out_adv;
   assign accept    = req.valid && req.ready;

   // ---------------------------------------------------------------------
   // Stage 0: per-series state and the EWMA recursion (registered feedback loop)
   // ---------------------------------------------------------------------
   logic [LOAD_BITS-1:0] long_prev_ff;
   logic [LOAD_BITS-1:0] short_prev_ff;
   logic [LOAD_BITS-1:0] first_long_ff;
   logic [DAYS_W-1:0]    days_seen_ff;
   logic [PTR_W-1:0]     history_ptr_ff;

   logic [LOAD_BITS-1:0] long_last;
   logic [LOAD_BITS-1:0] short_last;
   logic [DAYS_W-1:0]    day;
   logic [LOAD_BITS-1:0] long_in;
   logic [LOAD_BITS-1:0] short_in;
   logic [DAYS_W-1:0]    days_seen_in;
   logic [PTR_W-1:0]     history_ptr_in;
   logic [CNT_W-1:0]     win;
   logic [CNT_W-1:0]     ptr_ext;
   logic [CNT_W-1:0]     slot_wide;
   logic [PTR_W-1:0]     slot;
   logic                 day_zero;
   logic                 ramp_zero;
   logic                 use_hist;

   always_comb begin
      // a new series starts from zero loads
      long_last  = req.first_day ? '0 : long_prev_ff;
      short_last = req.first_day ? '0 : short_prev_ff;
      day        = req.first_day ? '0 : days_seen_ff;

      if (req.seeded) begin
         long_in  = req.seed_load;
         short_in = req.seed_load;
      end else begin
         long_in  = ewma_step(long_last,  req.day_stress, long_decay_ff);
         short_in = ewma_step(short_last, req.day_stress, short_decay_ff);
      end

      days_seen_in   = (day == DAYS_MAX) ? DAYS_MAX : day + DAYS_W'(1);
      history_ptr_in = (history_ptr_ff == PTR_LAST) ? '0 : history_ptr_ff + PTR_W'(1);

      // window limited to the history that the RAM holds
      win = (CNT_W'(window_days_ff) > WIN_CAP) ? WIN_CAP : CNT_W'(window_days_ff);

      // history slot of the day one window back
      ptr_ext   = CNT_W'(history_ptr_ff);
      slot_wide = (ptr_ext >= win) ? ptr_ext - win : ptr_ext + DEPTH_C - win;
      slot      = slot_wide[PTR_W-1:0];

      day_zero  = (day == '0);
      ramp_zero = day_zero || (win == '0);
      use_hist  = (CNT_W'(day) >= win);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_prev_ff   <= '0;
         short_prev_ff  <= '0;
         first_long_ff  <= '0;
         days_seen_ff   <= '0;
         history_ptr_ff <= '0;
      end else if (accept) begin
         long_prev_ff   <= long_in;
         short_prev_ff  <= short_in;
         days_seen_ff   <= days_seen_in;
         history_ptr_ff <= history_ptr_in;
         if (day_zero) begin
            first_long_ff <= long_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Long load history. Today's load is written at ptr while the slot one
   // window back is read; the read data is only used with a window of at
   // least one day, where the two addresses never meet, so no forwarding.
   // ---------------------------------------------------------------------
   logic [LOAD_BITS-1:0] hist_q;

   tlet_ram #(
      .WIDTH (LOAD_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (history_ptr_ff),
      .wr_data (long_in),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (hist_q)
   );

   // ---------------------------------------------------------------------
   // Stage 1 registers
   // ---------------------------------------------------------------------
   logic [LOAD_BITS-1:0] s1_long_ff;
   logic [LOAD_BITS-1:0] s1_short_ff;
   logic [LOAD_BITS-1:0] s1_first_long_ff;
   logic                 s1_first_ff;
   logic                 s1_ramp_zero_ff;
   logic                 s1_use_hist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_long_ff       <= long_in;
         s1_short_ff      <= short_in;
         s1_first_long_ff <= first_long_ff;
         s1_first_ff      <= day_zero;
         s1_ramp_zero_ff  <= ramp_zero;
         s1_use_hist_ff   <= use_hist;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1 logic: balance and ramp
   // ---------------------------------------------------------------------
   logic signed [LOAD_BITS:0] balance_prev_ff;
   logic signed [LOAD_BITS:0] today_bal;
   logic signed [LOAD_BITS:0] bal;
   logic signed [LOAD_BITS:0] ramp;
   logic [LOAD_BITS-1:0]      ramp_ref;

   always_comb begin
      today_bal = load_diff(s1_long_ff, s1_short_ff);
      // yesterday mode: the previous day's balance, zero on a series' first day
      if (balance_today_ff) begin
         bal = today_bal;
      end else if (s1_first_ff) begin
         bal = '0;
      end else begin
         bal = balance_prev_ff;
      end

      ramp_ref = s1_use_hist_ff ? hist_q : s1_first_long_ff;
      ramp     = s1_ramp_zero_ff ? '0 : load_diff(s1_long_ff, ramp_ref);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         balance_prev_ff <= '0;
      end else if (s1_adv) begin
         balance_prev_ff <= today_bal;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [LOAD_BITS-1:0]      out_long_ff;
   logic [LOAD_BITS-1:0]      out_short_ff;
   logic signed [LOAD_BITS:0] out_bal_ff;
   logic signed [LOAD_BITS:0] out_ramp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_long_ff  <= s1_long_ff;
         out_short_ff <= s1_short_ff;
         out_bal_ff   <= bal;
         out_ramp_ff  <= ramp;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.long_load  = out_long_ff;
   assign rsp.short_load = out_short_ff;
   assign rsp.balance    = out_bal_ff;
   assign rsp.ramp       = out_ramp_ff;

endmodule

`default_nettype wire
